FILE: sv/bqb_pkg.sv
`timescale 1ns / 1ps

package bqb_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int MODE_W      = 3;
    localparam int COORD_W     = 17;
    localparam int HLEN_W      = 24;
    localparam int IDX_W       = 4;
    localparam int RES_W       = 32;
    localparam int NUM_BASIS   = 9;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 200;
    localparam int MODE_LSB    = 0;
    localparam int CX_LSB      = MODE_LSB + MODE_W;
    localparam int CY_LSB      = CX_LSB + COORD_W;
    localparam int HX_LSB      = CY_LSB + COORD_W;
    localparam int HY_LSB      = HX_LSB + HLEN_W;

    localparam int DIV_W       = 40;
    localparam int DIV_STEP    = 4;
    localparam int DIV_STG     = DIV_W / DIV_STEP;
    localparam int REM_W       = HLEN_W + 1;
    localparam int NSTG        = DIV_STG + 4;

    localparam int PSI_W       = 21;
    localparam int DPSI_W      = 37;
    localparam int INV_W       = 33;
    localparam int INV2_W      = 50;
    localparam int AMAG_W      = INV2_W + 3;
    localparam int BMAG_W      = DPSI_W;
    localparam int LO_W        = (AMAG_W + 1) / 2;
    localparam int HI_W        = AMAG_W - LO_W;
    localparam int NPROD       = 6;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BASIS - 1);

    typedef enum logic [1:0] {
        FI_0,
        FI_1,
        FI_2
    } t_fidx;

    typedef struct packed {
        logic             neg;
        logic [PSI_W-1:0] mag;
    } t_psi;

    typedef struct packed {
        logic              neg;
        logic [DPSI_W-1:0] mag;
    } t_dpsi;

    typedef struct packed {
        t_psi  [2:0]       psi;
        t_dpsi [2:0]       dpsi;
        logic [INV2_W-1:0] inv2;
    } t_axis;

    typedef struct packed {
        logic                   neg;
        logic [LO_W+BMAG_W-1:0] lo;
        logic [HI_W+BMAG_W-1:0] hi;
    } t_prod;

    typedef struct packed {
        logic [DIV_W-1:0] w;
        logic [REM_W-1:0] rem;
    } t_dstep;

    function automatic t_fidx node_ix(input logic [IDX_W-1:0] k);
        t_fidx f;
        case (k)
            4'd1, 4'd2, 4'd5: f = FI_1;
            4'd4, 4'd6, 4'd8: f = FI_2;
            default:          f = FI_0;
        endcase
        return f;
    endfunction

    function automatic t_fidx node_iy(input logic [IDX_W-1:0] k);
        t_fidx f;
        case (k)
            4'd2, 4'd3, 4'd6: f = FI_1;
            4'd5, 4'd7, 4'd8: f = FI_2;
            default:          f = FI_0;
        endcase
        return f;
    endfunction

endpackage

FILE: sv/bqb_axis.sv
`timescale 1ns / 1ps

module bqb_axis (
    input  logic                           i_clk,
    input  logic [bqb_pkg::NSTG-1:0]       i_en,
    input  logic [bqb_pkg::COORD_W-1:0]    i_coord,
    input  logic [bqb_pkg::HLEN_W-1:0]     i_hlen,
    output bqb_pkg::t_axis                 o_axis
);

    localparam int F     = bqb_pkg::FRAC_BITS;
    localparam int TT_W  = 2 * bqb_pkg::COORD_W;
    localparam int ARG_W = 40;
    localparam int A_W   = 22;
    localparam int SQ_W  = 2 * bqb_pkg::INV_W;
    localparam int DS    = bqb_pkg::DIV_STG;

    function automatic bqb_pkg::t_psi round_psi(input logic signed [ARG_W-1:0] v);
        logic [ARG_W-1:0] m;
        bqb_pkg::t_psi    p;
        m     = v[ARG_W-1] ? ARG_W'(-v) : ARG_W'(v);
        m     = m + (ARG_W'(1) << (F - 1));
        p.neg = v[ARG_W-1];
        p.mag = bqb_pkg::PSI_W'(m >> F);
        return p;
    endfunction

    function automatic bqb_pkg::t_dstep div_step(input logic [bqb_pkg::DIV_W-1:0] w,
                                                 input logic [bqb_pkg::REM_W-1:0] rem,
                                                 input logic [bqb_pkg::REM_W-1:0] d);
        logic [bqb_pkg::DIV_W-1:0] ww;
        logic [bqb_pkg::REM_W-1:0] rr;
        logic [bqb_pkg::REM_W:0]   tr;
        bqb_pkg::t_dstep           s;
        ww = w;
        rr = rem;
        for (int b = 0; b < bqb_pkg::DIV_STEP; b++) begin
            tr = {rr, ww[bqb_pkg::DIV_W-1]};
            ww = ww << 1;
            if (tr >= {1'b0, d}) begin
                tr    = tr - {1'b0, d};
                ww[0] = 1'b1;
            end
            rr = tr[bqb_pkg::REM_W-1:0];
        end
        s.w   = ww;
        s.rem = rr;
        return s;
    endfunction

    logic [bqb_pkg::COORD_W-1:0] r_t0, r_t1;
    logic [bqb_pkg::HLEN_W-1:0]  r_h0, r_h1;
    logic [TT_W-1:0]             r_tt1;

    logic signed [ARG_W-1:0]     ts, tt, arg0, arg1, arg2;
    logic signed [A_W-1:0]       t4, sc, a0, a1, a2;
    logic [A_W-1:0]              m0, m1, m2;
    bqb_pkg::t_psi [2:0]         n_psi;

    logic [bqb_pkg::DIV_W-1:0]   r_w   [DS+1][4];
    logic [bqb_pkg::REM_W-1:0]   r_rem [DS+1][4];
    logic [bqb_pkg::REM_W-1:0]   r_d   [DS+1];
    bqb_pkg::t_psi [2:0]         r_psi [DS+1];
    logic [2:0]                  r_dneg[DS+1];

    logic [bqb_pkg::INV_W-1:0]   inv;
    logic [SQ_W-1:0]             sq;
    bqb_pkg::t_axis              r_out;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_t0 <= i_coord;
            r_h0 <= (i_hlen == '0) ? bqb_pkg::HLEN_W'(1) : i_hlen;
        end
        if (i_en[1]) begin
            r_t1  <= r_t0;
            r_h1  <= r_h0;
            r_tt1 <= TT_W'(r_t0) * TT_W'(r_t0);
        end
    end

    always_comb begin
        ts   = ARG_W'(r_t1) << F;
        tt   = ARG_W'(r_tt1);
        arg0 = (ARG_W'(1) << (2 * F)) - (ts <<< 1) - ts + (tt <<< 1);
        arg1 = (tt <<< 1) - ts;
        arg2 = (ts <<< 2) - (tt <<< 2);
        n_psi[0] = round_psi(arg0);
        n_psi[1] = round_psi(arg1);
        n_psi[2] = round_psi(arg2);
        t4 = A_W'(r_t1) << 2;
        sc = A_W'(1) << F;
        a0 = t4 - (sc <<< 1) - sc;
        a1 = t4 - sc;
        a2 = (sc <<< 2) - (t4 <<< 1);
        m0 = a0[A_W-1] ? A_W'(-a0) : A_W'(a0);
        m1 = a1[A_W-1] ? A_W'(-a1) : A_W'(a1);
        m2 = a2[A_W-1] ? A_W'(-a2) : A_W'(a2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_w[0][0] <= (bqb_pkg::DIV_W'(m0) << (F + 1)) + bqb_pkg::DIV_W'(r_h1);
            r_w[0][1] <= (bqb_pkg::DIV_W'(m1) << (F + 1)) + bqb_pkg::DIV_W'(r_h1);
            r_w[0][2] <= (bqb_pkg::DIV_W'(m2) << (F + 1)) + bqb_pkg::DIV_W'(r_h1);
            r_w[0][3] <= (bqb_pkg::DIV_W'(1) << (2 * F + 1)) + bqb_pkg::DIV_W'(r_h1);
            for (int i = 0; i < 4; i++) begin
                r_rem[0][i] <= '0;
            end
            r_d[0]    <= {r_h1, 1'b0};
            r_psi[0]  <= n_psi;
            r_dneg[0] <= {a2[A_W-1], a1[A_W-1], a0[A_W-1]};
        end
        for (int j = 1; j <= DS; j++) begin
            if (i_en[j+2]) begin
                for (int i = 0; i < 4; i++) begin
                    {r_w[j][i], r_rem[j][i]} <= div_step(r_w[j-1][i], r_rem[j-1][i], r_d[j-1]);
                end
                r_d[j]    <= r_d[j-1];
                r_psi[j]  <= r_psi[j-1];
                r_dneg[j] <= r_dneg[j-1];
            end
        end
    end

    always_comb begin
        inv = r_w[DS][3][bqb_pkg::INV_W-1:0];
        sq  = SQ_W'(inv) * SQ_W'(inv);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[bqb_pkg::NSTG-1]) begin
            r_out.psi  <= r_psi[DS];
            r_out.inv2 <= bqb_pkg::INV2_W'((sq + (SQ_W'(1) << (F - 1))) >> F);
            for (int i = 0; i < 3; i++) begin
                r_out.dpsi[i].neg <= r_dneg[DS][i];
                r_out.dpsi[i].mag <= r_w[DS][i][bqb_pkg::DPSI_W-1:0];
            end
        end
    end

    assign o_axis = r_out;

endmodule

FILE: sv/bqb_emit.sv
`timescale 1ns / 1ps

module bqb_emit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [bqb_pkg::MODE_W-1:0]        i_mode,
    input  bqb_pkg::t_axis                    i_x,
    input  bqb_pkg::t_axis                    i_y,
    output logic                              o_pop,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [bqb_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                              o_m_tlast
);

    localparam int AW    = bqb_pkg::AMAG_W;
    localparam int BW    = bqb_pkg::BMAG_W;
    localparam int LW    = bqb_pkg::LO_W;
    localparam int SUM_W = AW + BW + 1;
    localparam int RW    = bqb_pkg::RES_W;
    localparam int PAD_W = bqb_pkg::OUT_TDATA_W - bqb_pkg::IDX_W - bqb_pkg::NPROD * RW;

    function automatic bqb_pkg::t_prod mul(input logic neg, input logic [AW-1:0] a,
                                           input logic [BW-1:0] b);
        bqb_pkg::t_prod p;
        p.neg = neg;
        p.lo  = (LW + BW)'(a[LW-1:0]) * (LW + BW)'(b);
        p.hi  = (bqb_pkg::HI_W + BW)'(a[AW-1:LW]) * (bqb_pkg::HI_W + BW)'(b);
        return p;
    endfunction

    function automatic logic [RW-1:0] finish(input bqb_pkg::t_prod p);
        logic [SUM_W-1:0] s;
        logic [SUM_W-1:0] r;
        logic [RW-1:0]    v;
        s = SUM_W'(p.lo) + (SUM_W'(p.hi) << LW);
        r = (s + (SUM_W'(1) << (bqb_pkg::FRAC_BITS - 1))) >> bqb_pkg::FRAC_BITS;
        if (p.neg) begin
            v = (r >= (SUM_W'(1) << (RW - 1))) ? {1'b1, {(RW-1){1'b0}}} : RW'(0) - r[RW-1:0];
        end else begin
            v = (r >= (SUM_W'(1) << (RW - 1))) ? {1'b0, {(RW-1){1'b1}}} : r[RW-1:0];
        end
        return v;
    endfunction

    logic [bqb_pkg::IDX_W-1:0]  r_k, n_k;
    logic                       r_p1_v;
    logic [bqb_pkg::IDX_W-1:0]  r_p1_k;
    logic [bqb_pkg::MODE_W-1:0] r_p1_mode;
    bqb_pkg::t_prod [bqb_pkg::NPROD-1:0] r_p1, n_p1;
    logic                       r_o_v;
    logic [bqb_pkg::IDX_W-1:0]  r_o_k;
    logic [RW-1:0]              r_o_f [bqb_pkg::NPROD];

    bqb_pkg::t_fidx             ix, iy;
    bqb_pkg::t_psi              px, py;
    bqb_pkg::t_dpsi             dx, dy;
    logic [AW-1:0]              ddx, ddy;
    logic                       o_can, p1_can, sel;
    logic                       want_v, want_d1, want_d2;

    always_comb begin
        o_can  = !r_o_v || i_m_tready;
        p1_can = !r_p1_v || o_can;
        sel    = i_valid && p1_can;
        o_pop  = sel && (r_k == bqb_pkg::LAST_IDX);
        n_k    = r_k;
        if (sel) begin
            n_k = o_pop ? '0 : r_k + 1'b1;
        end
        ix  = bqb_pkg::node_ix(r_k);
        iy  = bqb_pkg::node_iy(r_k);
        px  = i_x.psi[ix];
        py  = i_y.psi[iy];
        dx  = i_x.dpsi[ix];
        dy  = i_y.dpsi[iy];
        ddx = (ix == bqb_pkg::FI_2) ? AW'(i_x.inv2) << 3 : AW'(i_x.inv2) << 2;
        ddy = (iy == bqb_pkg::FI_2) ? AW'(i_y.inv2) << 3 : AW'(i_y.inv2) << 2;
        n_p1[0] = mul(px.neg ^ py.neg, AW'(px.mag), BW'(py.mag));
        n_p1[1] = mul(dx.neg ^ py.neg, AW'(dx.mag), BW'(py.mag));
        n_p1[2] = mul(dy.neg ^ px.neg, AW'(dy.mag), BW'(px.mag));
        n_p1[3] = mul((ix == bqb_pkg::FI_2) ^ py.neg, ddx, BW'(py.mag));
        n_p1[4] = mul((iy == bqb_pkg::FI_2) ^ px.neg, ddy, BW'(px.mag));
        n_p1[5] = mul(dx.neg ^ dy.neg, AW'(dx.mag), dy.mag);
        want_v  = r_p1_mode[0];
        want_d1 = r_p1_mode[1] || r_p1_mode[2];
        want_d2 = r_p1_mode[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_p1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            r_k <= n_k;
            if (p1_can) begin
                r_p1_v <= i_valid;
            end
            if (o_can) begin
                r_o_v <= r_p1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p1_can) begin
            r_p1      <= n_p1;
            r_p1_k    <= r_k;
            r_p1_mode <= i_mode;
        end
        if (o_can) begin
            r_o_k    <= r_p1_k;
            r_o_f[0] <= want_v  ? finish(r_p1[0]) : '0;
            r_o_f[1] <= want_d1 ? finish(r_p1[1]) : '0;
            r_o_f[2] <= want_d1 ? finish(r_p1[2]) : '0;
            r_o_f[3] <= want_d2 ? finish(r_p1[3]) : '0;
            r_o_f[4] <= want_d2 ? finish(r_p1[4]) : '0;
            r_o_f[5] <= want_d2 ? finish(r_p1[5]) : '0;
        end
    end

    assign o_m_tvalid = r_o_v;
    assign o_m_tlast  = (r_o_k == bqb_pkg::LAST_IDX);
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_o_f[5], r_o_f[4], r_o_f[3], r_o_f[2],
                         r_o_f[1], r_o_f[0], r_o_k};

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v && !o_m_tlast |-> r_o_k < bqb_pkg::LAST_IDX)
        else $error("basis index beyond the last function");

    a_p1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_v && o_can |=> r_o_v && r_o_k == $past(r_p1_k))
        else $error("product stage lost a result");

    a_k_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !sel |=> r_k == $past(r_k))
        else $error("basis counter moved without a selection");

endmodule

FILE: sv/biquadratic_quad_basis_eval_top.sv
`timescale 1ns / 1ps
// Channel | Direction | Contents
// s       | in        | one evaluation point: mode, x, y, hx, hy
// m       | out       | nine results per point, tlast on the ninth
//
// A point passes fourteen input stages (input register, square, set-up, ten divider
// stages of four quotient bits each, then 1/h squared) and two result stages.
// New points enter while earlier ones are still in the stages, and the result port
// carries one basis function per cycle while it is not stalled. Reset clears the valid
// bits and the basis counter. A stall on the result side holds each occupied stage that
// has no empty stage after it, empty stages still fill, and no transaction is lost.

module biquadratic_quad_basis_eval_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // mode[2:0], coord_x[19:3], coord_y[36:20], edge_len_x[60:37], edge_len_y[84:61]
    input  logic [bqb_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // basis_index[3:0], basis_value[35:4], deriv_x[67:36], deriv_y[99:68],
    // deriv_xx[131:100], deriv_yy[163:132], deriv_xy[195:164]
    output logic [bqb_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic                               o_m_tlast
);

    localparam int NS = bqb_pkg::NSTG;

    logic [NS-1:0]              r_v;
    logic [bqb_pkg::MODE_W-1:0] r_mode [NS];
    logic [NS-1:0]              can;
    logic                       pop;
    bqb_pkg::t_axis             ax_x, ax_y;

    always_comb begin
        can[NS-1] = !r_v[NS-1] || pop;
        for (int s = NS - 2; s >= 0; s--) begin
            can[s] = !r_v[s] || can[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (can[0]) begin
                r_v[0] <= i_s_tvalid;
            end
            for (int s = 1; s < NS; s++) begin
                if (can[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (can[0]) begin
            r_mode[0] <= i_s_tdata[bqb_pkg::MODE_LSB +: bqb_pkg::MODE_W];
        end
        for (int s = 1; s < NS; s++) begin
            if (can[s]) begin
                r_mode[s] <= r_mode[s-1];
            end
        end
    end

    assign o_s_tready = can[0];

    bqb_axis u_axis_x (
        .i_clk   (i_clk),
        .i_en    (can),
        .i_coord (i_s_tdata[bqb_pkg::CX_LSB +: bqb_pkg::COORD_W]),
        .i_hlen  (i_s_tdata[bqb_pkg::HX_LSB +: bqb_pkg::HLEN_W]),
        .o_axis  (ax_x)
    );

    bqb_axis u_axis_y (
        .i_clk   (i_clk),
        .i_en    (can),
        .i_coord (i_s_tdata[bqb_pkg::CY_LSB +: bqb_pkg::COORD_W]),
        .i_hlen  (i_s_tdata[bqb_pkg::HY_LSB +: bqb_pkg::HLEN_W]),
        .o_axis  (ax_y)
    );

    bqb_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v[NS-1]),
        .i_mode     (r_mode[NS-1]),
        .i_x        (ax_x),
        .i_y        (ax_y),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
